FILE: rtl/core/lfu_pkg.sv
package lfu_pkg;

  // Operation codes carried in the func field
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_ONE = 32'd1;

  // Reset value of the capacity register
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  // One cache slot as held in the entry memory
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] count;
    logic [63:0] touch;
  } entry_t;

  // Summary of one scan over the slots
  typedef struct packed {
    logic found;
    logic have_min;
    logic have_free;
  } scan_flags_t;

  // Raise a use count, holding it at the top
  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == COUNT_MAX) ? c : c + 32'd1;
  endfunction

endpackage

FILE: rtl/core/lfu_req_if.sv
interface lfu_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] key_in;
  logic [31:0] value_in;

  modport source (output valid, func, key_in, value_in, input ready);
  modport sink   (input valid, func, key_in, value_in, output ready);
endinterface

FILE: rtl/core/lfu_resp_if.sv
interface lfu_resp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_value;
  logic        evicted;
  logic [31:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

FILE: rtl/core/lfu_scan.sv
module lfu_scan #(
  parameter int ENTRIES = 16,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int UW = $clog2(ENTRIES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr,
  input  logic                 sample,
  input  logic [IW-1:0]        idx,
  input  logic                 slot_valid,
  input  logic [31:0]          key,
  input  lfu_pkg::entry_t      entry,
  output lfu_pkg::scan_flags_t flags,
  output logic [IW-1:0]        match_idx,
  output logic [IW-1:0]        min_idx,
  output logic [IW-1:0]        free_idx,
  output lfu_pkg::entry_t      match_entry,
  output lfu_pkg::entry_t      min_entry,
  output logic [UW-1:0]        used
);
  import lfu_pkg::*;

  logic take_match;
  logic take_min;
  logic take_free;

  assign take_match = sample && slot_valid && (entry.key == key) && !flags.found;
  // strict compare keeps the lowest slot on a full tie
  assign take_min   = sample && slot_valid &&
                      (!flags.have_min ||
                       ({entry.count, entry.touch} < {min_entry.count, min_entry.touch}));
  assign take_free  = sample && !slot_valid && !flags.have_free;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      flags <= '0;
      used  <= '0;
    end else begin
      if (take_match) flags.found     <= 1'b1;
      if (take_min)   flags.have_min  <= 1'b1;
      if (take_free)  flags.have_free <= 1'b1;
      if (sample && slot_valid) used <= used + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      match_idx   <= idx;
      match_entry <= entry;
    end
    if (take_min) begin
      min_idx   <= idx;
      min_entry <= entry;
    end
    if (take_free) free_idx <= idx;
  end

endmodule

FILE: rtl/core/lfu_cache_policy.sv
// Channel  Dir  Handshake          Contents
// req      in   valid/ready        func, key_in, value_in
// resp     out  valid/ready        hit, read_value, evicted, evicted_key
// cfg      in   cfg_we (no wait)   cfg_wdata: capacity
//
// Each request runs from acceptance to a result in the output register through S_SCAN
// (one entry memory read per slot through its single read port), S_FLUSH (drain the
// last read), S_DECIDE (decide and write back) and S_DONE (load the result). req.ready
// returns the cycle after the load, so a new request is taken only once the last is done.
// A result waiting on resp does not block the next request; only its own load waits.
// Reset (rst, synchronous) clears the valid bits, the tick and the capacity to 16.
module lfu_cache_policy #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  lfu_req_if.sink    req,
  lfu_resp_if.source resp
);
  import lfu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int CW = (UW > 5) ? UW : 5;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DECIDE,
    S_DONE
  } state_t;

  state_t state;

  // Configuration and global state
  logic [4:0]        capacity;
  logic [63:0]       tick;
  logic [ENTRIES-1:0] slot_vld;

  // Held request
  logic        req_func;
  logic [31:0] req_key;
  logic [31:0] req_value;

  // Scan sequencing
  logic [IW-1:0] cnt;
  logic          chk_vld;
  logic [IW-1:0] chk_idx;

  // Entry memory: one read port, one write port
  entry_t mem [ENTRIES];
  entry_t mem_q;

  // Scan results
  scan_flags_t   flags;
  logic [IW-1:0] match_idx, min_idx, free_idx;
  entry_t        match_entry, min_entry;
  logic [UW-1:0] used;

  // Decision
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  entry_t        wr_entry;
  logic          set_vld;
  logic [31:0]   res_rd;
  logic          res_ev;
  logic [31:0]   res_evk;
  logic [CW-1:0] cap_ext, cap_eff;
  logic          full;

  // Pending result and output register
  logic        pend_hit;
  logic [31:0] pend_rd;
  logic        pend_ev;
  logic [31:0] pend_evk;
  logic        resp_vld;
  logic        resp_hit;
  logic [31:0] resp_rd;
  logic        resp_ev;
  logic [31:0] resp_evk;

  logic accept;
  logic load;

  assign accept = req.valid && req.ready;
  assign load   = (state == S_DONE) && (!resp_vld || resp.ready);

  assign req.ready        = (state == S_IDLE);
  assign resp.valid       = resp_vld;
  assign resp.hit         = resp_hit;
  assign resp.read_value  = resp_rd;
  assign resp.evicted     = resp_ev;
  assign resp.evicted_key = resp_evk;

  // Capacity beyond the slot count acts as the slot count
  assign cap_ext = CW'(capacity);
  assign cap_eff = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
  assign full    = (CW'(used) >= cap_eff);

  always_ff @(posedge clk) begin
    mem_q <= mem[cnt];
    if (wr_en) mem[wr_idx] <= wr_entry;
  end

  lfu_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .clr         (accept),
    .sample      (chk_vld),
    .idx         (chk_idx),
    .slot_valid  (slot_vld[chk_idx]),
    .key         (req_key),
    .entry       (mem_q),
    .flags       (flags),
    .match_idx   (match_idx),
    .min_idx     (min_idx),
    .free_idx    (free_idx),
    .match_entry (match_entry),
    .min_entry   (min_entry),
    .used        (used)
  );

  // Work out the write-back and the result once the scan has settled
  always_comb begin
    wr_en          = 1'b0;
    wr_idx         = match_idx;
    wr_entry.key   = req_key;
    wr_entry.value = match_entry.value;
    wr_entry.count = bump(match_entry.count);
    wr_entry.touch = tick;
    set_vld        = 1'b0;
    res_rd         = '0;
    res_ev         = 1'b0;
    res_evk        = '0;
    if (state == S_DECIDE) begin
      if (req_func == FUNC_GET) begin
        if (flags.found) begin
          wr_en  = 1'b1;
          res_rd = match_entry.value;
        end
      end else if (cap_eff != '0) begin
        wr_en          = 1'b1;
        wr_entry.value = req_value;
        if (!flags.found) begin
          // new key: replace the least used, oldest slot or fill a free one
          wr_entry.count = COUNT_ONE;
          set_vld        = 1'b1;
          if (full) begin
            wr_idx  = min_idx;
            res_ev  = 1'b1;
            res_evk = min_entry.key;
          end else begin
            wr_idx = free_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CAPACITY_RESET;
      tick     <= '0;
      slot_vld <= '0;
      chk_vld  <= 1'b0;
      resp_vld <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (load) resp_vld <= 1'b1;
      else if (resp.ready) resp_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          chk_vld <= 1'b0;
          if (accept) begin
            tick  <= tick + 64'd1;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one slot read a cycle; check it the cycle after
          chk_vld <= 1'b1;
          if (cnt == LAST) state <= S_FLUSH;
        end
        S_FLUSH: begin
          chk_vld <= 1'b0;
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (set_vld) slot_vld[wr_idx] <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) state <= S_IDLE;
        end
        default: begin
          chk_vld <= 1'b0;
          state   <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: hold request, advance scan pointer, capture result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= req.func;
      req_key   <= req.key_in;
      req_value <= req.value_in;
      cnt       <= '0;
    end else if (state == S_SCAN && cnt != LAST) begin
      cnt <= cnt + IW'(1);
    end
    chk_idx <= cnt;
    if (state == S_DECIDE) begin
      pend_hit <= flags.found;
      pend_rd  <= res_rd;
      pend_ev  <= res_ev;
      pend_evk <= res_evk;
    end
    if (load) begin
      resp_hit <= pend_hit;
      resp_rd  <= pend_rd;
      resp_ev  <= pend_ev;
      resp_evk <= pend_evk;
    end
  end

endmodule

FILE: rtl/core/lfu_policy_chk.sv
module lfu_policy_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        resp_valid,
  input logic        resp_ready,
  input logic        hit,
  input logic [31:0] read_value,
  input logic        evicted,
  input logic [31:0] evicted_key
);

  // A stalled result holds its contents
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=>
      resp_valid && $stable(hit) && $stable(read_value) &&
      $stable(evicted) && $stable(evicted_key))
    else $error("stalled response changed");

  // No eviction is reported together with a hit
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> !(evicted && hit))
    else $error("eviction reported on a hit");

  // Unused result fields read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> (evicted || evicted_key == 32'd0) &&
                   ((hit && !evicted) || read_value == 32'd0))
    else $error("unused response field not zero");

  // Each request occupies the block for a scan
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready ##1 !req_ready)
    else $error("request taken during a scan");

endmodule

bind lfu_cache_policy lfu_policy_chk u_policy_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .resp_valid  (resp.valid),
  .resp_ready  (resp.ready),
  .hit         (resp.hit),
  .read_value  (resp.read_value),
  .evicted     (resp.evicted),
  .evicted_key (resp.evicted_key)
);
